// File: rtl/oid_dec_pkg.sv
// Shared types and constants for the object identifier arc decoder.
package oid_dec_pkg;

   // Arc count at which an identifier with bytes still left is an error.
   localparam int unsigned MAX_ARCS = 20;

   // 2^64 = 40 * ARC_Q_WRAP + ARC_R_WRAP; used when the accumulator wraps.
   localparam logic [58:0] ARC_Q_WRAP = 59'd461168601842738790;
   localparam logic [4:0]  ARC_R_WRAP = 5'd16;

   localparam logic [5:0]  ARC_DIVISOR = 6'd40;

   // Bias that keeps the small remainder term non-negative (51 * 40).
   localparam logic [12:0] REM_BIAS     = 13'd2040;
   localparam logic [7:0]  REM_BIAS_DIV = 8'd51;

   // Reciprocal of 5 scaled by 2^10, exact for inputs below 1024.
   localparam logic [7:0]  RECIP_FIVE = 8'd205;

   localparam int unsigned FIFO_DEPTH = 4;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_HEADER2,
      PH_BODY,
      PH_DISCARD
   } phase_type;

   typedef struct packed {
      logic        arc_valid;
      logic [63:0] arc_value;
      logic [4:0]  arc_index;
      logic        message_end;
      logic        status;
   } result_type;

endpackage

// File: rtl/oid_arc_base128_decoder_core.sv
// Object identifier arc decoder: length header, base-128 arcs and output queue.
//
// The req channel carries one encoded byte per transfer: req_tdata holds the
// byte and req_tuser flags the first header byte of a new message. Each
// completed subidentifier produces one result on the rsp channel; the first
// one produces two (quotient and remainder by 40) unless relative mode is set.
// rsp_tdata holds the arc value and index, rsp_tuser the valid and status
// flags, and rsp_tlast marks the last result of the identifier.
// Each result is registered into the output queue before it appears on rsp.
// One byte is taken every cycle while req_tready is high. The quotient by
// 40 is kept up to date as each byte is shifted in, so no divider stands in
// the path. A result pair fills two slots of the four-entry output queue,
// and req_tready is low while fewer than two slots are free. When the
// receiver stalls, the queue fills and req_tready falls.
// csr_wen writes the relative mode bit; write it only while idle.
// Synchronous reset returns the decoder to waiting for a length header and
// empties the queue; there is no clearing pass.
module oid_arc_base128_decoder_core
   import oid_dec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] message_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] arc_value, [68:64] arc_index, [71:69] zero
   output logic [1:0]  rsp_tuser,   // [0] arc_valid, [1] status
   output logic        rsp_tlast,   // message_end
   input  logic        csr_wen,
   input  logic        csr_wdata    // relative_mode
);

   localparam int PtrW = $clog2(FIFO_DEPTH);

   phase_type   phase_ff, phase_in;
   logic        relative_mode_ff;
   logic [6:0]  header_high_ff, header_high_in;
   logic [14:0] remaining_ff, remaining_in;
   logic [63:0] acc_ff, acc_in;
   logic [58:0] quot_ff, quot_in;
   logic [5:0]  rem40_ff, rem40_in;
   logic [4:0]  arcs_ff, arcs_in;

   result_type  fifo_ff [FIFO_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]   count_ff, count_in;

   logic        req_accept, rsp_pop;
   logic [6:0]  low7;
   logic        take_header;
   logic [14:0] length_val;
   logic        length_zero;
   logic [14:0] rem_dec;
   logic [63:0] acc_shift;
   logic        sub_continue, msg_done, split, overflow;
   logic [4:0]  arcs_split;
   logic [6:0]  wrap_k;
   logic [12:0] small_x;
   logic [17:0] small_prod;
   logic [7:0]  small_q;
   logic [12:0] small_q40;
   logic [5:0]  rem40_next;
   logic [58:0] quot_next;
   result_type  res0, res1;
   logic [1:0]  push_n;
   logic        err_push;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= (PtrW+1)'(FIFO_DEPTH - 2));

   assign low7        = req_tdata[6:0];
   assign take_header = req_tuser || (phase_ff == PH_HEADER);
   assign length_val  = take_header ? {8'd0, low7} : {header_high_ff, req_tdata};
   assign length_zero = (length_val == 15'd0);

   assign rem_dec      = remaining_ff - 15'd1;
   assign acc_shift    = {acc_ff[56:0], low7};
   assign sub_continue = req_tdata[7] && (rem_dec != 15'd0);
   assign msg_done     = (rem_dec == 15'd0);
   assign split        = !relative_mode_ff && (arcs_ff == 5'd0);
   assign arcs_split   = split ? 5'd1 : arcs_ff;
   assign overflow     = !msg_done && (({1'b0, arcs_split} + 6'd1) >= 6'(MAX_ARCS));

   // Track quotient and remainder by 40 of the truncated accumulator. The
   // bits shifted out above bit 63 subtract wrap_k copies of 2^64.
   assign wrap_k     = acc_ff[63:57];
   assign small_x    = {rem40_ff, low7} + REM_BIAS - 13'({wrap_k, 4'd0});
   assign small_prod = 18'(small_x[12:3]) * 18'(RECIP_FIVE);
   assign small_q    = small_prod[17:10];
   assign small_q40  = 13'(small_q) * 13'(ARC_DIVISOR);
   assign rem40_next = 6'(small_x - small_q40);
   assign quot_next  = {quot_ff[51:0], 7'd0} + 59'(small_q) - 59'(REM_BIAS_DIV)
                       - 59'(59'(wrap_k) * ARC_Q_WRAP);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (req_accept) begin
         if (take_header) begin
            if (req_tdata[7]) begin
               phase_in = PH_HEADER2;
            end else begin
               phase_in = length_zero ? PH_HEADER : PH_BODY;
            end
         end else begin
            unique case (phase_ff)
               PH_HEADER2: begin
                  phase_in = length_zero ? PH_HEADER : PH_BODY;
               end
               PH_BODY: begin
                  if (!sub_continue) begin
                     if (msg_done) begin
                        phase_in = PH_HEADER;
                     end else if (overflow) begin
                        phase_in = PH_DISCARD;
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // Datapath updates and results.
   always_comb begin
      header_high_in = header_high_ff;
      remaining_in   = remaining_ff;
      acc_in         = acc_ff;
      quot_in        = quot_ff;
      rem40_in       = rem40_ff;
      arcs_in        = arcs_ff;
      res0           = '0;
      res1           = '0;
      push_n         = 2'd0;
      err_push       = 1'b0;
      if (req_accept) begin
         if (take_header && req_tdata[7]) begin
            header_high_in = low7;
            remaining_in   = 15'd0;
            acc_in         = '0;
            quot_in        = '0;
            rem40_in       = '0;
            arcs_in        = '0;
         end else if (take_header || (phase_ff == PH_HEADER2)) begin
            remaining_in = length_val;
            acc_in       = '0;
            quot_in      = '0;
            rem40_in     = '0;
            arcs_in      = '0;
            if (length_zero) begin
               if (!relative_mode_ff) begin
                  res0.arc_valid   = 1'b1;
                  res1.arc_valid   = 1'b1;
                  res1.arc_index   = 5'd1;
                  res1.message_end = 1'b1;
                  push_n           = 2'd2;
               end else begin
                  res0.message_end = 1'b1;
                  push_n           = 2'd1;
               end
            end
         end else if (phase_ff == PH_BODY) begin
            remaining_in = rem_dec;
            if (sub_continue) begin
               acc_in   = acc_shift;
               quot_in  = quot_next;
               rem40_in = rem40_next;
            end else begin
               acc_in   = '0;
               quot_in  = '0;
               rem40_in = '0;
               arcs_in  = arcs_split + 5'd1;
               err_push = overflow;
               if (split) begin
                  res0.arc_valid   = 1'b1;
                  res0.arc_value   = 64'(quot_next);
                  res1.arc_valid   = 1'b1;
                  res1.arc_value   = 64'(rem40_next);
                  res1.arc_index   = arcs_split;
                  res1.message_end = msg_done || overflow;
                  res1.status      = overflow;
                  push_n           = 2'd2;
               end else begin
                  res0.arc_valid   = 1'b1;
                  res0.arc_value   = acc_shift;
                  res0.arc_index   = arcs_ff;
                  res0.message_end = msg_done || overflow;
                  res0.status      = overflow;
                  push_n           = 2'd1;
               end
            end
         end
      end
   end

   assign count_in = count_ff + (PtrW+1)'(push_n) - (PtrW+1)'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         relative_mode_ff <= 1'b0;
         header_high_ff   <= '0;
         remaining_ff     <= '0;
         acc_ff           <= '0;
         quot_ff          <= '0;
         rem40_ff         <= '0;
         arcs_ff          <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         phase_ff       <= phase_in;
         header_high_ff <= header_high_in;
         remaining_ff   <= remaining_in;
         acc_ff         <= acc_in;
         quot_ff        <= quot_in;
         rem40_ff       <= rem40_in;
         arcs_ff        <= arcs_in;
         wr_ptr_ff      <= wr_ptr_ff + PtrW'(push_n);
         rd_ptr_ff      <= rd_ptr_ff + PtrW'(rsp_pop);
         count_ff       <= count_in;
         if (csr_wen) begin
            relative_mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + PtrW'(1)] <= res1;
      end
   end

   result_type head;
   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {3'd0, head.arc_index, head.arc_value};
   assign rsp_tuser  = {head.status, head.arc_valid};
   assign rsp_tlast  = head.message_end;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrW+1)'(FIFO_DEPTH))
      else $error("output queue count exceeds its depth");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem40_ff < ARC_DIVISOR)
      else $error("running remainder by 40 out of range");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!req_accept && !rsp_pop) |=> $stable(count_ff))
      else $error("queue count changed without a transfer");

   a_discard_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_in == PH_DISCARD && phase_ff != PH_DISCARD) |-> err_push)
      else $error("discard entered without an error result");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tlast && rsp_tuser[0]))
      else $error("error result not marked as last valid arc");

endmodule
